// ===== rtl/lr_pkg.sv =====
package lr_pkg;

   localparam int LR_COORD_BITS = 16;
   localparam int LR_INDEX_BITS = 16;
   localparam int LR_QUEUE_DEPTH = 4;

   localparam logic signed [LR_COORD_BITS-1:0] LR_COORD_ONE = LR_COORD_BITS'(1);
   localparam logic [LR_INDEX_BITS-1:0] LR_INDEX_ONE = LR_INDEX_BITS'(1);

   typedef enum logic [0:0] {
      LR_OP_START = 1'b0,
      LR_OP_NEXT  = 1'b1
   } lr_op_type;

   typedef struct packed {
      lr_op_type                       req_type;
      logic signed [LR_COORD_BITS-1:0] x_start;
      logic signed [LR_COORD_BITS-1:0] y_start;
      logic signed [LR_COORD_BITS-1:0] x_end;
      logic signed [LR_COORD_BITS-1:0] y_end;
   } lr_req_type;

   typedef struct packed {
      logic signed [LR_COORD_BITS-1:0] point_x;
      logic signed [LR_COORD_BITS-1:0] point_y;
      logic [LR_INDEX_BITS-1:0]        point_index;
      logic                            last_point;
   } lr_rsp_type;

   // Classified request handed from the front end to the stepper.
   typedef struct packed {
      lr_op_type                       op;
      logic                            steep;
      logic                            minor_down;
      logic signed [LR_COORD_BITS-1:0] major_pos;
      logic signed [LR_COORD_BITS-1:0] major_end;
      logic signed [LR_COORD_BITS-1:0] minor_pos;
      logic [LR_COORD_BITS-1:0]        delta_major;
      logic [LR_COORD_BITS-1:0]        delta_minor;
   } lr_cmd_type;

endpackage

// ===== rtl/lr_front.sv =====
module lr_front
   import lr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  lr_req_type req_payload,
   output logic       cmd_valid,
   input  logic       cmd_ready,
   output lr_cmd_type cmd
);

   localparam int C = LR_COORD_BITS;

   logic       valid_ff, valid_in;
   lr_cmd_type cmd_ff, cmd_in;

   logic signed [C:0] dx, dy, dmaj_raw, dmin_raw;
   logic [C:0]        adx_w, ady_w;
   logic [C-1:0]      adx, ady;
   logic              steep, flip, minor_up;
   logic signed [C-1:0] maj_s, maj_e, min_s, min_e;

   // Setup: differences, steep test, axis swap, ordering along the major axis.
   always_comb begin
      dx = {req_payload.x_end[C-1], req_payload.x_end}
         - {req_payload.x_start[C-1], req_payload.x_start};
      dy = {req_payload.y_end[C-1], req_payload.y_end}
         - {req_payload.y_start[C-1], req_payload.y_start};
      adx_w = dx[C] ? -dx : dx;
      ady_w = dy[C] ? -dy : dy;
      adx = adx_w[C-1:0];
      ady = ady_w[C-1:0];
      steep = ady > adx;

      maj_s    = steep ? req_payload.y_start : req_payload.x_start;
      maj_e    = steep ? req_payload.y_end   : req_payload.x_end;
      min_s    = steep ? req_payload.x_start : req_payload.y_start;
      min_e    = steep ? req_payload.x_end   : req_payload.y_end;
      dmaj_raw = steep ? dy : dx;
      dmin_raw = steep ? dx : dy;
      flip     = dmaj_raw[C];
      minor_up = flip ? dmin_raw[C] : (!dmin_raw[C] && (dmin_raw != '0));

      cmd_in.op          = req_payload.req_type;
      cmd_in.steep       = steep;
      cmd_in.minor_down  = !minor_up;
      cmd_in.major_pos   = flip ? maj_e : maj_s;
      cmd_in.major_end   = flip ? maj_s : maj_e;
      cmd_in.minor_pos   = flip ? min_e : min_s;
      cmd_in.delta_major = steep ? ady : adx;
      cmd_in.delta_minor = steep ? adx : ady;
   end

   assign req_ready = !valid_ff || cmd_ready;
   assign cmd_valid = valid_ff;
   assign cmd       = cmd_ff;

   always_comb begin
      valid_in = valid_ff && !cmd_ready;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule

// ===== rtl/lr_queue.sv =====
module lr_queue
   import lr_pkg::*;
#(
   parameter int DEPTH = LR_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push_valid,
   output logic       push_ready,
   input  lr_cmd_type push_cmd,
   output logic       pop_valid,
   input  logic       pop_ready,
   output lr_cmd_type pop_cmd
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
   localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);
   localparam logic [PTR_BITS-1:0] PTR_ONE  = PTR_BITS'(1);
   localparam logic [CNT_BITS-1:0] CNT_ONE  = CNT_BITS'(1);

   lr_cmd_type          mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                push, pop;

   assign push_ready = count_ff != CNT_FULL;
   assign pop_valid  = count_ff != '0;
   assign pop_cmd    = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_ONE;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_ONE;
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_ONE;
      end else if (pop && !push) begin
         count_in = count_ff - CNT_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/lr_back.sv =====
module lr_back
   import lr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       cmd_valid,
   output logic       cmd_ready,
   input  lr_cmd_type cmd,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output lr_rsp_type rsp_payload
);

   localparam int C = LR_COORD_BITS;

   logic                active_ff, active_in;
   logic                steep_ff, steep_in;
   logic                down_ff, down_in;
   logic signed [C-1:0] major_pos_ff, major_pos_in;
   logic signed [C-1:0] major_end_ff, major_end_in;
   logic signed [C-1:0] minor_pos_ff, minor_pos_in;
   logic [C-1:0]        dmin_ff, dmin_in;
   logic [C-1:0]        ddiff_ff, ddiff_in;
   logic signed [C:0]   err_ff, err_in;
   logic [LR_INDEX_BITS-1:0] count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   lr_rsp_type          rsp_payload_ff, rsp_payload_in;

   logic                take, last;
   logic signed [C:0]   err_sub, err_add;

   assign cmd_ready   = !rsp_valid_ff || rsp_ready;
   assign take        = cmd_valid && cmd_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // Both error candidates in parallel; the sign of the first picks one.
   assign err_sub = err_ff - $signed({1'b0, dmin_ff});
   assign err_add = err_ff + $signed({1'b0, ddiff_ff});
   assign last    = major_pos_ff >= major_end_ff;

   always_comb begin
      active_in      = active_ff;
      steep_in       = steep_ff;
      down_in        = down_ff;
      major_pos_in   = major_pos_ff;
      major_end_in   = major_end_ff;
      minor_pos_in   = minor_pos_ff;
      dmin_in        = dmin_ff;
      ddiff_in       = ddiff_ff;
      err_in         = err_ff;
      count_in       = count_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;
      if (take) begin
         unique case (cmd.op)
            LR_OP_START: begin
               active_in    = 1'b1;
               steep_in     = cmd.steep;
               down_in      = cmd.minor_down;
               major_pos_in = cmd.major_pos;
               major_end_in = cmd.major_end;
               minor_pos_in = cmd.minor_pos;
               dmin_in      = cmd.delta_minor;
               ddiff_in     = cmd.delta_major - cmd.delta_minor;
               err_in       = $signed({2'b00, cmd.delta_major[C-1:1]});
               count_in     = '0;
            end
            LR_OP_NEXT: begin
               if (active_ff) begin
                  rsp_valid_in               = 1'b1;
                  rsp_payload_in.point_x     = steep_ff ? minor_pos_ff : major_pos_ff;
                  rsp_payload_in.point_y     = steep_ff ? major_pos_ff : minor_pos_ff;
                  rsp_payload_in.point_index = count_ff;
                  rsp_payload_in.last_point  = last;
                  count_in = count_ff + LR_INDEX_ONE;
                  if (err_sub[C]) begin
                     minor_pos_in = down_ff ? minor_pos_ff - LR_COORD_ONE
                                            : minor_pos_ff + LR_COORD_ONE;
                     err_in = err_add;
                  end else begin
                     err_in = err_sub;
                  end
                  if (last) begin
                     active_in = 1'b0;
                  end else begin
                     major_pos_in = major_pos_ff + LR_COORD_ONE;
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      steep_ff       <= steep_in;
      down_ff        <= down_in;
      major_pos_ff   <= major_pos_in;
      major_end_ff   <= major_end_in;
      minor_pos_ff   <= minor_pos_in;
      dmin_ff        <= dmin_in;
      ddiff_ff       <= ddiff_in;
      err_ff         <= err_in;
      count_ff       <= count_in;
      rsp_payload_ff <= rsp_payload_in;
   end

endmodule

// ===== rtl/line_rasterizer_core.sv =====
// Bresenham line generator with a pull interface.
// Request channel (req_valid/req_ready/req_payload): a start request carries two
// signed endpoints and sets up a line, producing no response; a next request
// pulls one point of the active line and produces exactly one response, or none
// when no line is active. A start abandons any line in progress.
// Response channel (rsp_valid/rsp_ready/rsp_payload): the point in original
// axes, its index within the line and a flag on the final endpoint.
// Path: an accepted next request passes the front setup register, the command
// queue and the output register, in that order, before its response is valid.
// Throughput: one request per cycle, start or next, while nothing stalls; the
// stepper makes one error-term update per cycle unless the output register is
// held by a stalled receiver.
// A stalled receiver holds the output register; the stepper then stops, the
// command queue (QUEUE_DEPTH entries) fills, and req_ready drops only once the
// front register also holds a request.
// Reset clears the active-line flag, the queue and all valid flags; after it
// next requests produce nothing until a start request arrives.
module line_rasterizer_core
   import lr_pkg::*;
#(
   parameter int QUEUE_DEPTH = LR_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  lr_req_type req_payload,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output lr_rsp_type rsp_payload
);

   // Front end to queue.
   logic       fq_valid, fq_ready;
   lr_cmd_type fq_cmd;

   // Queue to stepper.
   logic       qb_valid, qb_ready;
   lr_cmd_type qb_cmd;

   // Classify each request and do the line setup for starts.
   lr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .cmd_valid   (fq_valid),
      .cmd_ready   (fq_ready),
      .cmd         (fq_cmd)
   );

   // Decouple setup from stepping so either side can stall on its own.
   lr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_cmd   (fq_cmd),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_cmd    (qb_cmd)
   );

   // Hold the line state, step the error term and drive the response register.
   lr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (qb_valid),
      .cmd_ready   (qb_ready),
      .cmd         (qb_cmd),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== rtl/lr_checker.sv =====
module lr_checker
   import lr_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input lr_rsp_type rsp_payload
);

   // A stalled response holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response dropped or changed while stalled");

   // Nothing is pending right after reset.
   a_rsp_clear: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // The front register is empty after reset.
   a_req_open: assert property (@(posedge clock)
      !reset && $past(reset) |-> req_ready)
      else $error("request channel blocked after reset");

   // No request accepted after reset can have crossed the three register stages yet.
   a_min_latency: assert property (@(posedge clock)
      !reset && $past(reset, 2) |-> !rsp_valid)
      else $error("response faster than the pipeline allows");

endmodule

bind line_rasterizer_core lr_checker u_lr_checker (.*);
